[rtl/core/restoring_divide_128_by_64_macros.svh]
// Assertion macros for the restoring divider checker.
`ifndef RESTORING_DIVIDE_128_BY_64_MACROS_SVH
`define RESTORING_DIVIDE_128_BY_64_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define RDIV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with a fixed delay in cycles.
`define RDIV_ASSERT_DLY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

[rtl/core/rdiv_pkg.sv]
// Shared types and constants of the restoring divider.
package rdiv_pkg;

	localparam int WORD_BITS = 64;
	localparam int DW_BITS   = 2 * WORD_BITS;
	localparam int LATENCY   = WORD_BITS;

	typedef struct packed {
		logic                 ovf;
		logic [DW_BITS-1:0]   rem;
		logic [DW_BITS-1:0]   sdiv;
		logic [WORD_BITS-1:0] quo;
	} rdiv_data_t;

endpackage

[rtl/core/restoring_divide_128_by_64.sv]
// Top level of the pipelined 128-by-64 restoring divider.
// Fully pipelined unsigned divider: one compare-subtract stage per quotient bit, so
// a transaction is accepted every cycle (busy stays low) and its result appears with
// done once it has passed through the registered stage chain. The result is shown
// for one cycle only and cannot be held off. overflow is set when dividend_high is
// not below divisor_value (a zero divisor included); quotient and remainder_low are
// then what the shift-subtract chain yields, e.g. all ones and dividend_low for a
// zero divisor.
module restoring_divide_128_by_64
	import rdiv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] dividend_high,
	input  logic [63:0] dividend_low,
	input  logic [63:0] divisor_value,
	output logic        done,
	output logic [63:0] quotient,
	output logic [63:0] remainder_low,
	output logic        overflow
);

	logic                 chain_valid [0:WORD_BITS];
	rdiv_data_t           chain_data  [0:WORD_BITS];
	logic [WORD_BITS-1:0] in_hi;
	logic [WORD_BITS-1:0] in_lo;
	logic [WORD_BITS-1:0] in_div;

	assign busy   = 1'b0;
	assign in_hi  = dividend_high[WORD_BITS-1:0];
	assign in_lo  = dividend_low[WORD_BITS-1:0];
	assign in_div = divisor_value[WORD_BITS-1:0];

	always_comb begin
		chain_valid[0]     = start && !busy;
		chain_data[0].ovf  = in_hi >= in_div;
		chain_data[0].rem  = {in_hi, in_lo};
		chain_data[0].sdiv = DW_BITS'(in_div) << (WORD_BITS - 1);
		chain_data[0].quo  = '0;
	end

	for (genvar g = 0; g < WORD_BITS; g++) begin : g_stage
		rdiv_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[g]),
			.in_data   (chain_data[g]),
			.out_valid (chain_valid[g+1]),
			.out_data  (chain_data[g+1])
		);
	end

	assign done          = chain_valid[WORD_BITS];
	assign quotient      = 64'(chain_data[WORD_BITS].quo);
	assign remainder_low = 64'(chain_data[WORD_BITS].rem[WORD_BITS-1:0]);
	assign overflow      = chain_data[WORD_BITS].ovf;

endmodule

[rtl/core/rdiv_stage.sv]
// One quotient bit: compare-subtract of the remainder against the shifted divisor.
module rdiv_stage
	import rdiv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  rdiv_data_t in_data,
	output logic       out_valid,
	output rdiv_data_t out_data
);

	logic [DW_BITS:0] diff;
	logic             ge;
	rdiv_data_t       nxt;
	logic             valid_s1;
	rdiv_data_t       data_s1;

	always_comb begin
		diff     = {1'b0, in_data.rem} - {1'b0, in_data.sdiv};
		ge       = !diff[DW_BITS];
		nxt.ovf  = in_data.ovf;
		nxt.rem  = ge ? diff[DW_BITS-1:0] : in_data.rem;
		nxt.sdiv = in_data.sdiv >> 1;
		nxt.quo  = {in_data.quo[WORD_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

[rtl/core/rdiv_checker.sv]
// Port-level checker for the restoring divider, bound to the top level.
`include "restoring_divide_128_by_64_macros.svh"

module rdiv_checker
	import rdiv_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [63:0] dividend_high,
	input logic [63:0] dividend_low,
	input logic [63:0] divisor_value,
	input logic        done,
	input logic [63:0] quotient,
	input logic [63:0] remainder_low,
	input logic        overflow
);

	`RDIV_ASSERT_DLY(a_accept_gives_done, start && !busy, LATENCY, done, "transaction lost")
	`RDIV_ASSERT_NOW(a_done_has_source, done, $past(start && !busy, LATENCY), "spurious result")
	`RDIV_ASSERT_NOW(a_overflow_flag, done, overflow == ($past(dividend_high[WORD_BITS-1:0], LATENCY) >= $past(divisor_value[WORD_BITS-1:0], LATENCY)), "overflow flag mismatch")
	`RDIV_ASSERT_NOW(a_zero_divisor, done && ($past(divisor_value[WORD_BITS-1:0], LATENCY) == '0), (quotient[WORD_BITS-1:0] == '1) && (remainder_low[WORD_BITS-1:0] == $past(dividend_low[WORD_BITS-1:0], LATENCY)), "zero divisor result wrong")

endmodule

bind restoring_divide_128_by_64 rdiv_checker u_rdiv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.dividend_high (dividend_high),
	.dividend_low  (dividend_low),
	.divisor_value (divisor_value),
	.done          (done),
	.quotient      (quotient),
	.remainder_low (remainder_low),
	.overflow      (overflow)
);

[sim/restoring_divide_checker.sv]
// Checker for the restoring divider: predicts each division and compares the results.
`timescale 1ns / 1ps

module restoring_divide_checker
	import rdiv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [WORD_BITS-1:0] dividend_high,
	input  logic [WORD_BITS-1:0] dividend_low,
	input  logic [WORD_BITS-1:0] divisor_value,
	input  logic                 done,
	input  logic [WORD_BITS-1:0] quotient,
	input  logic [WORD_BITS-1:0] remainder_low,
	input  logic                 overflow,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic [WORD_BITS-1:0] quo;
		logic [WORD_BITS-1:0] rem_lo;
		logic                 ovf;
	} division_result_t;

	division_result_t awaited_divisions[$];
	int               error_total = 0;
	int               awaited_total = 0;

	assign mismatches  = error_total;
	assign outstanding = awaited_total;

	function automatic division_result_t divide_restoring(
		input logic [WORD_BITS-1:0] hi,
		input logic [WORD_BITS-1:0] lo,
		input logic [WORD_BITS-1:0] dv
	);
		logic [DW_BITS-1:0] partial;
		logic [DW_BITS-1:0] shifted;
		division_result_t   r;
		partial = {hi, lo};
		r.quo   = '0;
		r.ovf   = (hi >= dv);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			shifted = {{WORD_BITS{1'b0}}, dv} << i;
			if (partial >= shifted) begin
				partial  = partial - shifted;
				r.quo[i] = 1'b1;
			end
		end
		r.rem_lo = partial[WORD_BITS-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		division_result_t oldest;
		if (arst_n) begin
			// results leave before the same edge's transaction is queued
			if (done) begin
				if (awaited_divisions.size() == 0) begin
					$error("result with no division outstanding: quotient %h remainder_low %h",
						quotient, remainder_low);
					error_total++;
				end else begin
					oldest = awaited_divisions.pop_front();
					if (quotient !== oldest.quo) begin
						$error("quotient: expected %h, got %h", oldest.quo, quotient);
						error_total++;
					end
					if (remainder_low !== oldest.rem_lo) begin
						$error("remainder_low: expected %h, got %h", oldest.rem_lo,
							remainder_low);
						error_total++;
					end
					if (overflow !== oldest.ovf) begin
						$error("overflow: expected %b, got %b", oldest.ovf, overflow);
						error_total++;
					end
				end
			end
			if (start && !busy)
				awaited_divisions.push_back(
					divide_restoring(dividend_high, dividend_low, divisor_value));
			awaited_total = awaited_divisions.size();
		end
	end

endmodule

[sim/tb_top.sv]
// Testbench top for the restoring divider: drives divisions and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
	import rdiv_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 1330;

	localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};
	localparam logic [WORD_BITS-1:0] TOP_BIT  = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [WORD_BITS-1:0] dividend_high;
	logic [WORD_BITS-1:0] dividend_low;
	logic [WORD_BITS-1:0] divisor_value;
	logic                 done;
	logic [WORD_BITS-1:0] quotient;
	logic [WORD_BITS-1:0] remainder_low;
	logic                 overflow;
	int                   mismatches;
	int                   outstanding;
	int                   idle_cycles = 0;
	bit                   quiet_stretch = 0;

	restoring_divide_128_by_64 uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.dividend_high (dividend_high),
		.dividend_low  (dividend_low),
		.divisor_value (divisor_value),
		.done          (done),
		.quotient      (quotient),
		.remainder_low (remainder_low),
		.overflow      (overflow)
	);

	restoring_divide_checker division_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.dividend_high (dividend_high),
		.dividend_low  (dividend_low),
		.divisor_value (divisor_value),
		.done          (done),
		.quotient      (quotient),
		.remainder_low (remainder_low),
		.overflow      (overflow),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [WORD_BITS-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [WORD_BITS-1:0] edge_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 1;
			2: return ALL_ONES;
			3: return TOP_BIT;
			4: return ALL_ONES >> 1;
			default: return rand_word();
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet_stretch)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 120);
	endfunction

	task automatic send_division(
		input logic [WORD_BITS-1:0] hi,
		input logic [WORD_BITS-1:0] lo,
		input logic [WORD_BITS-1:0] dv
	);
		int gap;
		@(negedge clk);
		start         <= 1'b1;
		dividend_high <= hi;
		dividend_low  <= lo;
		divisor_value <= dv;
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start         <= 1'b0;
			dividend_high <= rand_word();
			dividend_low  <= rand_word();
			divisor_value <= rand_word();
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_divisions();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic send_random_division();
		logic [WORD_BITS-1:0] hi;
		logic [WORD_BITS-1:0] lo;
		logic [WORD_BITS-1:0] dv;
		int                   sel;
		sel = $urandom_range(0, 99);
		lo  = rand_word();
		if (sel < 60) begin
			dv = rand_word() >> $urandom_range(0, WORD_BITS - 1);
			if (dv == 0)
				dv = 1;
			hi = ($urandom_range(0, 9) == 0) ? dv - 1 : rand_word() % dv;
		end else if (sel < 75) begin
			hi = rand_word();
			dv = hi >> $urandom_range(0, WORD_BITS - 1);
		end else if (sel < 80) begin
			hi = rand_word();
			dv = '0;
		end else if (sel < 90) begin
			dv = WORD_BITS'($urandom_range(1, 255));
			hi = WORD_BITS'($urandom_range(0, 32'(dv) - 1));
		end else begin
			hi = edge_word();
			lo = edge_word();
			dv = edge_word();
		end
		send_division(hi, lo, dv);
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		dividend_high = '0;
		dividend_low  = '0;
		divisor_value = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// extremes, exact-fit, overflow and zero divisor
		send_division('0, '0, 1);
		send_division('0, ALL_ONES, 1);
		send_division('0, ALL_ONES, ALL_ONES);
		send_division('0, '0, ALL_ONES);
		send_division(ALL_ONES - 1, ALL_ONES, ALL_ONES);
		send_division(ALL_ONES - 1, '0, ALL_ONES);
		send_division(TOP_BIT - 1, ALL_ONES, TOP_BIT);
		send_division('0, 100, 7);
		send_division(4, 7, 5);
		send_division(123, 456, ALL_ONES);
		send_division('0, '0, '0);
		send_division(ALL_ONES, ALL_ONES, '0);
		send_division('0, 12345, '0);
		send_division(ALL_ONES, ALL_ONES, ALL_ONES);
		send_division(5, 7, 5);
		send_division(6, '0, 5);
		send_division(ALL_ONES, '0, 1);
		send_division(TOP_BIT, ALL_ONES, TOP_BIT);
		send_division(ALL_ONES >> 1, ALL_ONES, TOP_BIT);
		send_division(1, '0, 2);
		drain_divisions();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0)
				quiet_stretch = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_ITEMS / 2)
				drain_divisions();
			send_random_division();
		end

		drain_divisions();
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
